/* rtl/sequence_gap_tracker_macros.svh */
// ----------------------------------------------------------------------------
// Sequence gap tracker assertion macros
// Shared property forms for the tracker checks; clocked on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef SEQUENCE_GAP_TRACKER_MACROS_SVH
`define SEQUENCE_GAP_TRACKER_MACROS_SVH

// same-cycle implication
`define SGT_ASSERT_NOW(label, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error("sequence_gap_tracker: same-cycle check failed");

// next-cycle implication
`define SGT_ASSERT_NEXT(label, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error("sequence_gap_tracker: next-cycle check failed");

`endif

/* rtl/sgt_pkg.sv */
// ----------------------------------------------------------------------------
// Sequence gap tracker package
// Constants, codes and helpers shared by the tracker RTL.
// ----------------------------------------------------------------------------
package sgt_pkg;

	localparam int GAP_DEPTH = 1024;
	localparam int GAP_AW    = $clog2(GAP_DEPTH);
	localparam int FILL_W    = $clog2(GAP_DEPTH + 1);
	localparam int VAL_W     = 32;
	localparam int CFG_W     = 31;

	localparam logic [7:0]       NEWLINE   = 8'd10;
	localparam logic [VAL_W-1:0] MAG_LIMIT = 32'h8000_0000;
	localparam logic [VAL_W-1:0] POS_MAX   = 32'h7FFF_FFFF;
	localparam logic [VAL_W-1:0] SEQ_RESET = 32'd1;

	localparam logic FUNC_BYTE = 1'b0;
	localparam logic FUNC_READ = 1'b1;
	localparam logic KIND_LINE = 1'b0;
	localparam logic KIND_READ = 1'b1;

	typedef enum logic [1:0] {
		VD_IN_ORDER  = 2'd0,
		VD_OLD       = 2'd1,
		VD_AHEAD     = 2'd2,
		VD_NO_NUMBER = 2'd3
	} sgt_verdict_t;

	typedef enum logic [1:0] {
		PH_SPACE  = 2'd0,
		PH_SIGN   = 2'd1,
		PH_DIGITS = 2'd2,
		PH_IGNORE = 2'd3
	} sgt_phase_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_JUDGE,
		ST_ROOM,
		ST_WRITE
	} sgt_state_t;

	function automatic logic is_ws(input logic [7:0] b);
		return (b == 8'd32) || ((b >= 8'd9) && (b <= 8'd13));
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= 8'd48) && (b <= 8'd57);
	endfunction

endpackage

/* rtl/sequence_gap_tracker.sv */
// ----------------------------------------------------------------------------
// Sequence gap tracker
// Parses newline-terminated decimal lines, checks them against the expected
// sequence number and logs skipped numbers in an on-chip gap store.
// ----------------------------------------------------------------------------
// Usage: issue a transaction by raising start while busy is low. func = 0
// feeds one text byte; func = 1 reads gap entry read_index. A plain byte
// leaves the tracker idle and gives no result. A newline passes the judge
// state (and the room state for an ahead line), then stays in the write state
// for each missing number stored, since the gap RAM has a single write port
// and takes one entry a cycle. A read passes the read state, which takes the
// registered RAM data. Each result shows on the result ports for exactly one
// cycle with done high, registered from the read, judge or room state that
// made it. The receiver cannot stall, so capture it then. For an ahead line
// busy stays high through the done cycle while gaps remain to be written, and
// the result already carries the final gap_count and expected_now as well.
// start_seq is written through cfg_valid/cfg_ready only while idle; it loads
// the expected number at once. The gap store needs no clearing after reset.
// ----------------------------------------------------------------------------
`include "sequence_gap_tracker_macros.svh"

module sequence_gap_tracker
	import sgt_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	// command channel
	input  logic                    start,
	output logic                    busy,
	input  logic                    func,
	input  logic [7:0]              data_byte,
	input  logic [GAP_AW-1:0]       read_index,
	// result channel
	output logic                    done,
	output logic                    kind,
	output logic [1:0]              verdict,
	output logic signed [VAL_W-1:0] line_value,
	output logic signed [VAL_W-1:0] expected_now,
	output logic [FILL_W-1:0]       gap_count,
	output logic                    gaps_dropped,
	output logic signed [VAL_W-1:0] gap_value,
	// configuration channel
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_W-1:0]        cfg_data
);

	// control state
	sgt_state_t        state_q, state_d;
	sgt_phase_t        phase_q, phase_d;
	logic [VAL_W-1:0]  acc_q, acc_d;
	logic              neg_q, neg_d;
	logic              got_q, got_d;
	logic [VAL_W-1:0]  exp_q, exp_d;
	logic [FILL_W-1:0] fill_q, fill_d;
	logic              drop_q, drop_d;
	logic [FILL_W-1:0] remain_q, remain_d;
	logic              done_q;

	// payload registers
	logic [VAL_W-1:0]  line_val_s1;
	logic              line_got_s1;
	logic [VAL_W-1:0]  count_s2;
	logic              in_range_q;
	logic [GAP_AW-1:0] wr_ptr_q;
	logic [VAL_W-1:0]  wr_val_q;

	// result registers
	logic              res_kind_q;
	sgt_verdict_t      res_verdict_q;
	logic [VAL_W-1:0]  res_line_q;
	logic [VAL_W-1:0]  res_exp_q;
	logic [FILL_W-1:0] res_fill_q;
	logic              res_drop_q;
	logic [VAL_W-1:0]  res_gap_q;

	// combinational
	logic              accept;
	logic              cfg_write;
	logic              emit;
	sgt_verdict_t      emit_verdict;
	logic              emit_kind;
	logic [VAL_W-1:0]  emit_line;
	logic [VAL_W-1:0]  emit_gap;
	logic              ram_we;
	logic [VAL_W-1:0]  ram_rdata;
	logic [3:0]        digit_val;
	logic [VAL_W+3:0]  acc_times10;
	logic [VAL_W-1:0]  acc_digit;
	logic [VAL_W-1:0]  line_pattern;
	logic [VAL_W-1:0]  diff;
	logic              is_less;
	logic              is_equal;
	logic [FILL_W-1:0] room;
	logic              count_lt_room;
	logic [FILL_W-1:0] take_n;

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);
	assign accept    = start && !busy;
	assign cfg_write = cfg_valid && cfg_ready;

	// digit accumulate: acc*10 + d, saturating at 2^31
	assign digit_val   = 4'(data_byte - 8'd48);
	assign acc_times10 = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + {32'b0, digit_val};
	assign acc_digit   = (acc_times10 > {4'b0, MAG_LIMIT}) ? MAG_LIMIT : acc_times10[VAL_W-1:0];

	// finished-line value as a two's complement pattern
	assign line_pattern = neg_q ? (VAL_W'(0) - acc_q) :
	                      ((acc_q >= MAG_LIMIT) ? POS_MAX : acc_q);

	// verdict compare (judge cycle)
	assign is_equal = (line_val_s1 == exp_q);
	assign is_less  = ($signed(line_val_s1) < $signed(exp_q));
	assign diff     = line_val_s1 - exp_q;

	// store room (room cycle)
	assign room          = FILL_W'(GAP_DEPTH) - fill_q;
	assign count_lt_room = (count_s2 < {{(VAL_W-FILL_W){1'b0}}, room});
	assign take_n        = count_lt_room ? count_s2[FILL_W-1:0] : room;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (func == FUNC_READ) begin
						state_d = ST_READ;
					end else if (data_byte == NEWLINE) begin
						state_d = ST_JUDGE;
					end
				end
			end
			ST_READ: begin
				state_d = ST_IDLE;
			end
			ST_JUDGE: begin
				if (line_got_s1 && !is_equal && !is_less) begin
					state_d = ST_ROOM;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_ROOM: begin
				state_d = (take_n != '0) ? ST_WRITE : ST_IDLE;
			end
			ST_WRITE: begin
				if (remain_q == FILL_W'(1)) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs and state updates
	always_comb begin
		phase_d      = phase_q;
		acc_d        = acc_q;
		neg_d        = neg_q;
		got_d        = got_q;
		exp_d        = exp_q;
		fill_d       = fill_q;
		drop_d       = drop_q;
		remain_d     = remain_q;
		emit         = 1'b0;
		emit_kind    = KIND_LINE;
		emit_verdict = VD_IN_ORDER;
		emit_line    = '0;
		emit_gap     = '0;
		ram_we       = 1'b0;

		if (cfg_write) begin
			exp_d = {1'b0, cfg_data};
		end

		unique case (state_q)
			ST_IDLE: begin
				if (accept && func == FUNC_BYTE) begin
					if (data_byte == NEWLINE) begin
						phase_d = PH_SPACE;
						acc_d   = '0;
						neg_d   = 1'b0;
						got_d   = 1'b0;
					end else begin
						unique case (phase_q)
							PH_SPACE: begin
								if (is_ws(data_byte)) begin
									phase_d = PH_SPACE;
								end else if (data_byte == 8'd43 || data_byte == 8'd45) begin
									neg_d   = (data_byte == 8'd45);
									phase_d = PH_SIGN;
								end else if (is_digit(data_byte)) begin
									acc_d   = acc_digit;
									got_d   = 1'b1;
									phase_d = PH_DIGITS;
								end else begin
									phase_d = PH_IGNORE;
								end
							end
							PH_SIGN, PH_DIGITS: begin
								if (is_digit(data_byte)) begin
									acc_d   = acc_digit;
									got_d   = 1'b1;
									phase_d = PH_DIGITS;
								end else begin
									phase_d = PH_IGNORE;
								end
							end
							PH_IGNORE: begin
								phase_d = PH_IGNORE;
							end
							default: begin
								phase_d = PH_IGNORE;
							end
						endcase
					end
				end
			end
			ST_READ: begin
				emit      = 1'b1;
				emit_kind = KIND_READ;
				emit_gap  = in_range_q ? ram_rdata : '0;
			end
			ST_JUDGE: begin
				if (!line_got_s1) begin
					emit         = 1'b1;
					emit_verdict = VD_NO_NUMBER;
				end else if (is_equal) begin
					emit         = 1'b1;
					emit_verdict = VD_IN_ORDER;
					emit_line    = line_val_s1;
					exp_d        = exp_q + VAL_W'(1);
				end else if (is_less) begin
					emit         = 1'b1;
					emit_verdict = VD_OLD;
					emit_line    = line_val_s1;
				end
			end
			ST_ROOM: begin
				emit         = 1'b1;
				emit_verdict = VD_AHEAD;
				emit_line    = line_val_s1;
				exp_d        = line_val_s1 + VAL_W'(1);
				fill_d       = fill_q + take_n;
				remain_d     = take_n;
				if (!count_lt_room && (count_s2 != {{(VAL_W-FILL_W){1'b0}}, room})) begin
					drop_d = 1'b1;
				end
			end
			ST_WRITE: begin
				ram_we   = 1'b1;
				remain_d = remain_q - FILL_W'(1);
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			phase_q  <= PH_SPACE;
			acc_q    <= '0;
			neg_q    <= 1'b0;
			got_q    <= 1'b0;
			exp_q    <= SEQ_RESET;
			fill_q   <= '0;
			drop_q   <= 1'b0;
			remain_q <= '0;
			done_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			phase_q  <= phase_d;
			acc_q    <= acc_d;
			neg_q    <= neg_d;
			got_q    <= got_d;
			exp_q    <= exp_d;
			fill_q   <= fill_d;
			drop_q   <= drop_d;
			remain_q <= remain_d;
			done_q   <= emit;
		end
	end

	// payload: line latch, gap count, write pointer, result transaction
	always_ff @(posedge clk) begin
		if (accept && func == FUNC_BYTE && data_byte == NEWLINE) begin
			line_val_s1 <= line_pattern;
			line_got_s1 <= got_q;
		end
		if (accept && func == FUNC_READ) begin
			in_range_q <= ({1'b0, read_index} < fill_q);
		end
		if (state_q == ST_JUDGE) begin
			count_s2 <= diff;
		end
		if (state_q == ST_ROOM) begin
			wr_ptr_q <= fill_q[GAP_AW-1:0];
			wr_val_q <= exp_q;
		end else if (ram_we) begin
			wr_ptr_q <= wr_ptr_q + GAP_AW'(1);
			wr_val_q <= wr_val_q + VAL_W'(1);
		end
		if (emit) begin
			res_kind_q    <= emit_kind;
			res_verdict_q <= emit_verdict;
			res_line_q    <= emit_line;
			res_exp_q     <= exp_d;
			res_fill_q    <= fill_d;
			res_drop_q    <= drop_d;
			res_gap_q     <= emit_gap;
		end
	end

	sgt_ram #(
		.WIDTH (VAL_W),
		.DEPTH (GAP_DEPTH)
	) u_gap_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr_ptr_q),
		.wdata (wr_val_q),
		.raddr (read_index),
		.rdata (ram_rdata)
	);

	assign done         = done_q;
	assign kind         = res_kind_q;
	assign verdict      = res_verdict_q;
	assign line_value   = res_line_q;
	assign expected_now = res_exp_q;
	assign gap_count    = res_fill_q;
	assign gaps_dropped = res_drop_q;
	assign gap_value    = res_gap_q;

	// fill count never passes the store depth
	`SGT_ASSERT_NOW(a_fill_bound, 1'b1, fill_q <= FILL_W'(GAP_DEPTH))
	// gap writes land only inside the already-counted region
	`SGT_ASSERT_NOW(a_write_in_fill, ram_we, ({1'b0, wr_ptr_q} < fill_q))
	// every state that emits a result is followed by one that does not, so results never come back to back
	`SGT_ASSERT_NEXT(a_done_spaced, done_q, !done_q)
	// pending gap writes keep the command side stalled
	`SGT_ASSERT_NOW(a_busy_writes, remain_q != '0, busy)

endmodule

/* rtl/sgt_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module sgt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule
